### hdl/http_request_line_parser_top_defines.svh
// Assertion macros shared by the request-line parser RTL.
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_DEFINES_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define HRLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("request-line parser check failed");

// Antecedent holds, so the consequent holds in the next cycle.
`define HRLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("request-line parser check failed");

`endif

### hdl/hrlp_pkg.sv
// Package with types, constants and keyword tables of the request-line parser.
`default_nettype none

package hrlp_pkg;

    localparam int LENGTH_BITS  = 16;
    localparam int TARGET_LEN_W = 16;
    localparam int CMP_W        = (LENGTH_BITS > TARGET_LEN_W) ? LENGTH_BITS + 1
                                                               : TARGET_LEN_W + 1;

    localparam logic [TARGET_LEN_W-1:0] MAX_LEN_RESET = TARGET_LEN_W'(2048);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [3:0] METHOD_NONE  = 4'd8;
    localparam logic [1:0] VERSION_NONE = 2'd3;
    localparam logic [3:0] TPOS_MAX     = 4'd15;
    localparam logic [3:0] VERSION_LEN  = 4'd8;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_METHOD,
        PH_GAP1,
        PH_TARGET,
        PH_GAP2,
        PH_VERSION,
        PH_TRAIL,
        PH_EXPECT_LF
    } t_phase;

    typedef enum logic [2:0] {
        ST_200 = 3'd0,
        ST_400 = 3'd1,
        ST_501 = 3'd2,
        ST_414 = 3'd3,
        ST_505 = 3'd4
    } t_status;

    typedef struct packed {
        logic                    kind;
        logic [7:0]              target_byte;
        t_status                 status;
        logic [3:0]              method_code;
        logic [1:0]              version_code;
        logic [TARGET_LEN_W-1:0] target_length;
    } t_result;

    localparam logic [63:0] METHOD_NAME [8] = '{
        64'("GET"), 64'("HEAD"), 64'("POST"), 64'("PUT"),
        64'("DELETE"), 64'("CONNECT"), 64'("OPTIONS"), 64'("TRACE")
    };
    localparam logic [3:0] METHOD_LEN [8] = '{
        4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5
    };
    localparam logic [63:0] VERSION_NAME [3] = '{
        64'("HTTP/1.0"), 64'("HTTP/1.1"), 64'("HTTP/2.0")
    };

    // Character of a method name at a position below its length.
    function automatic logic [7:0] method_char(input logic [2:0] idx,
                                               input logic [3:0] pos);
        logic [63:0] name;
        logic [3:0]  shift;
        name  = METHOD_NAME[idx];
        shift = METHOD_LEN[idx] - pos - 4'd1;
        return name[{shift[2:0], 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] version_char(input logic [1:0] idx,
                                                input logic [2:0] pos);
        logic [63:0] name;
        logic [2:0]  shift;
        name  = VERSION_NAME[idx];
        shift = 3'd7 - pos;
        return name[{shift, 3'b000} +: 8];
    endfunction

    function automatic logic [1:0] version_code(input logic [2:0] cand);
        logic [1:0] code;
        case (cand)
            3'b001:  code = 2'd0;
            3'b010:  code = 2'd1;
            3'b100:  code = 2'd2;
            default: code = VERSION_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### hdl/hrlp_core.sv
// Parser state and the single-pass step logic for one request byte.
`default_nettype none

module hrlp_core (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_step,
    input  wire logic                                     i_start,
    input  wire logic [7:0]                               i_byte,
    input  wire logic [hrlp_pkg::TARGET_LEN_W-1:0]        i_max_len,
    output      logic                                     o_res_valid,
    output      hrlp_pkg::t_result                        o_res
);

    localparam int LB = hrlp_pkg::LENGTH_BITS;
    localparam int OW = hrlp_pkg::TARGET_LEN_W;
    localparam int CW = hrlp_pkg::CMP_W;

    hrlp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [7:0]       r_mcand, n_mcand, e_mcand;
    logic [2:0]       r_vcand, n_vcand, e_vcand;
    logic [3:0]       r_tpos, n_tpos, e_tpos;
    logic [LB-1:0]    r_len, n_len, e_len;
    logic [3:0]       r_mfound, n_mfound, e_mfound;
    logic             r_vgiven, n_vgiven, e_vgiven;

    logic             ws, eol;
    logic [7:0]       m_fed, m_end;
    logic [3:0]       m_low;
    logic [2:0]       v_fed;
    logic [3:0]       v_pos, tpos_inc, v_tpos_inc;
    logic [LB:0]      len_next;
    logic [CW-1:0]    len_cmp, max_cmp;
    logic [OW+LB-1:0] len_wide;

    logic                  res_valid, pass;
    hrlp_pkg::t_status     status;
    logic [7:0]            pass_byte;

    always_comb begin
        e_phase  = r_phase;
        e_mcand  = r_mcand;
        e_vcand  = r_vcand;
        e_tpos   = r_tpos;
        e_len    = r_len;
        e_mfound = r_mfound;
        e_vgiven = r_vgiven;
        if (i_start) begin
            e_phase  = hrlp_pkg::PH_LEAD;
            e_mcand  = 8'hFF;
            e_vcand  = 3'b111;
            e_tpos   = 4'd0;
            e_len    = '0;
            e_mfound = hrlp_pkg::METHOD_NONE;
            e_vgiven = 1'b0;
        end
    end

    always_comb begin
        ws  = (i_byte == hrlp_pkg::CH_SPACE) || (i_byte == hrlp_pkg::CH_TAB);
        eol = (i_byte == hrlp_pkg::CH_CR) || (i_byte == hrlp_pkg::CH_LF);
        tpos_inc = (e_tpos == hrlp_pkg::TPOS_MAX) ? e_tpos : e_tpos + 4'd1;
        v_pos    = (e_phase == hrlp_pkg::PH_GAP2) ? 4'd0 : e_tpos;
        v_tpos_inc = (v_pos == hrlp_pkg::TPOS_MAX) ? v_pos : v_pos + 4'd1;
        for (int i = 0; i < 8; i++) begin
            m_fed[i] = e_mcand[i] && (e_tpos < hrlp_pkg::METHOD_LEN[i])
                       && (hrlp_pkg::method_char(3'(i), e_tpos) == i_byte);
            m_end[i] = e_mcand[i] && (e_tpos == hrlp_pkg::METHOD_LEN[i]);
        end
        m_low = hrlp_pkg::METHOD_NONE;
        for (int i = 7; i >= 0; i--) begin
            if (m_end[i]) begin
                m_low = 4'(i);
            end
        end
        for (int i = 0; i < 3; i++) begin
            v_fed[i] = e_vcand[i] && (v_pos < hrlp_pkg::VERSION_LEN)
                       && (hrlp_pkg::version_char(2'(i), v_pos[2:0]) == i_byte);
        end
        len_next = {1'b0, e_len} + {{LB{1'b0}}, 1'b1};
        len_cmp  = CW'(len_next);
        max_cmp  = CW'(i_max_len);
    end

    always_comb begin
        n_phase   = e_phase;
        n_mcand   = e_mcand;
        n_vcand   = e_vcand;
        n_tpos    = e_tpos;
        n_len     = e_len;
        n_mfound  = e_mfound;
        n_vgiven  = e_vgiven;
        res_valid = 1'b0;
        pass      = 1'b0;
        pass_byte = 8'd0;
        status    = hrlp_pkg::ST_200;
        if (!e_vgiven) begin
            case (e_phase)
                hrlp_pkg::PH_LEAD, hrlp_pkg::PH_METHOD: begin
                    if (e_phase == hrlp_pkg::PH_METHOD && (ws || eol)) begin
                        n_mcand = m_end;
                        if (m_end == 8'd0) begin
                            res_valid = 1'b1;
                            status    = hrlp_pkg::ST_501;
                        end else begin
                            n_mfound = m_low;
                            if (eol) begin
                                res_valid = 1'b1;
                                status    = hrlp_pkg::ST_400;
                            end else begin
                                n_phase = hrlp_pkg::PH_GAP1;
                            end
                        end
                    end else if (e_phase == hrlp_pkg::PH_LEAD && ws) begin
                        n_phase = e_phase;
                    end else if (e_phase == hrlp_pkg::PH_LEAD && eol) begin
                        res_valid = 1'b1;
                        status    = hrlp_pkg::ST_400;
                    end else begin
                        n_phase = hrlp_pkg::PH_METHOD;
                        n_mcand = m_fed;
                        n_tpos  = tpos_inc;
                        if (m_fed == 8'd0) begin
                            res_valid = 1'b1;
                            status    = hrlp_pkg::ST_501;
                        end
                    end
                end
                hrlp_pkg::PH_GAP1, hrlp_pkg::PH_TARGET: begin
                    if (ws) begin
                        if (e_phase == hrlp_pkg::PH_TARGET) begin
                            n_phase = hrlp_pkg::PH_GAP2;
                        end
                    end else if (eol) begin
                        res_valid = 1'b1;
                        status    = hrlp_pkg::ST_400;
                    end else begin
                        n_phase   = hrlp_pkg::PH_TARGET;
                        n_len     = len_next[LB] ? {LB{1'b1}} : len_next[LB-1:0];
                        res_valid = 1'b1;
                        if (len_cmp > max_cmp) begin
                            status = hrlp_pkg::ST_414;
                        end else begin
                            pass      = 1'b1;
                            pass_byte = i_byte;
                        end
                    end
                end
                hrlp_pkg::PH_GAP2, hrlp_pkg::PH_VERSION: begin
                    if (e_phase == hrlp_pkg::PH_VERSION && (ws || eol)) begin
                        if (e_tpos != hrlp_pkg::VERSION_LEN || e_vcand == 3'd0) begin
                            n_vcand   = 3'd0;
                            res_valid = 1'b1;
                            status    = hrlp_pkg::ST_505;
                        end else if (ws) begin
                            n_phase = hrlp_pkg::PH_TRAIL;
                        end else if (i_byte == hrlp_pkg::CH_CR) begin
                            n_phase = hrlp_pkg::PH_EXPECT_LF;
                        end else begin
                            res_valid = 1'b1;
                            status    = hrlp_pkg::ST_400;
                        end
                    end else if (e_phase == hrlp_pkg::PH_GAP2 && ws) begin
                        n_phase = e_phase;
                    end else if (e_phase == hrlp_pkg::PH_GAP2 && eol) begin
                        res_valid = 1'b1;
                        status    = hrlp_pkg::ST_400;
                    end else begin
                        n_phase = hrlp_pkg::PH_VERSION;
                        n_vcand = v_fed;
                        n_tpos  = v_tpos_inc;
                        if (v_fed == 3'd0) begin
                            res_valid = 1'b1;
                            status    = hrlp_pkg::ST_505;
                        end
                    end
                end
                hrlp_pkg::PH_TRAIL: begin
                    if (i_byte == hrlp_pkg::CH_CR) begin
                        n_phase = hrlp_pkg::PH_EXPECT_LF;
                    end else if (!ws) begin
                        res_valid = 1'b1;
                        status    = hrlp_pkg::ST_400;
                    end
                end
                hrlp_pkg::PH_EXPECT_LF: begin
                    res_valid = 1'b1;
                    status    = (i_byte == hrlp_pkg::CH_LF) ? hrlp_pkg::ST_200
                                                            : hrlp_pkg::ST_400;
                end
                default: begin
                    n_phase = e_phase;
                end
            endcase
        end
        if (res_valid && !pass) begin
            n_vgiven = 1'b1;
        end
    end

    always_comb begin
        len_wide            = {{OW{1'b0}}, n_len};
        o_res_valid         = res_valid;
        o_res.kind          = !pass;
        o_res.target_byte   = pass_byte;
        o_res.status        = status;
        o_res.method_code   = n_mfound;
        o_res.version_code  = hrlp_pkg::version_code(n_vcand);
        o_res.target_length = len_wide[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrlp_pkg::PH_LEAD;
            r_mcand  <= 8'hFF;
            r_vcand  <= 3'b111;
            r_tpos   <= 4'd0;
            r_len    <= '0;
            r_mfound <= hrlp_pkg::METHOD_NONE;
            r_vgiven <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_mcand  <= n_mcand;
            r_vcand  <= n_vcand;
            r_tpos   <= n_tpos;
            r_len    <= n_len;
            r_mfound <= n_mfound;
            r_vgiven <= n_vgiven;
        end
    end

endmodule

`default_nettype wire

### hdl/http_request_line_parser_top.sv
// Top level of the request-line parser: input register, parser core, result register.
// A byte's result is registered when the core takes it, as the input register refills.
// Throughput: one byte per cycle unless the output stalls.
// The parser core compares a byte against all method or version candidates in parallel.
// Reset is synchronous and active low; it empties both registers, clears the parser
// and sets the target length limit to 2048.
`default_nettype none

module http_request_line_parser_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire logic                                 i_start_req,
    input  wire logic [7:0]                           i_byte_in,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      logic                                 o_kind,
    output      logic [7:0]                           o_target_byte,
    output      logic [2:0]                           o_status,
    output      logic [3:0]                           o_method_code,
    output      logic [1:0]                           o_version_code,
    output      logic [hrlp_pkg::TARGET_LEN_W-1:0]    o_target_length,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hrlp_pkg::TARGET_LEN_W-1:0]    i_cfg_wdata
);

`include "http_request_line_parser_top_defines.svh"

    logic                                 r_in_valid, n_in_valid;
    logic                                 r_in_start;
    logic [7:0]                           r_in_byte;
    logic                                 r_out_valid, n_out_valid;
    hrlp_pkg::t_result                    r_out;
    logic [hrlp_pkg::TARGET_LEN_W-1:0]    r_max_len;
    logic                                 advance, in_accept;
    logic                                 res_valid;
    hrlp_pkg::t_result                    res;

    assign advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;

    hrlp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_start     (r_in_start),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = res_valid;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_len   <= hrlp_pkg::MAX_LEN_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_start <= i_start_req;
            r_in_byte  <= i_byte_in;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_target_byte   = r_out.target_byte;
    assign o_status        = r_out.status;
    assign o_method_code   = r_out.method_code;
    assign o_version_code  = r_out.version_code;
    assign o_target_length = r_out.target_length;

    `HRLP_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in_byte))
    `HRLP_ASSERT_NOW(a_pass_ok, o_out_valid && !o_kind,
        o_status == hrlp_pkg::ST_200 && o_target_length != '0)
    `HRLP_ASSERT_NOW(a_verdict_byte, o_out_valid && o_kind, o_target_byte == 8'd0)
    `HRLP_ASSERT_NOW(a_status_range, o_out_valid, o_status <= hrlp_pkg::ST_505)

endmodule

`default_nettype wire
